[rtl/core/wmrc_pkg.sv]
// shared types, flag positions and defaults for the westgard multirule checker
package wmrc_pkg;

    // default run lengths
    localparam int MEAN_RUN_DEFAULT    = 10;
    localparam int ONE_DEV_RUN_DEFAULT = 4;

    // widths
    localparam int SAMPLE_W = 16;
    localparam int STD_W    = 15;
    localparam int THR_W    = 19;
    localparam int ZONE_W   = 6;
    localparam int SEEN_W   = 4;

    // register indexes
    localparam logic [0:0] CFG_TARGET_MEAN = 1'b0;
    localparam logic [0:0] CFG_STD_DEV     = 1'b1;

    // bit positions in the zone flags
    localparam int ZB_HI2 = 0;
    localparam int ZB_LO2 = 1;
    localparam int ZB_HI1 = 2;
    localparam int ZB_LO1 = 3;
    localparam int ZB_POS = 4;
    localparam int ZB_NEG = 5;

    typedef enum logic [1:0] {
        RULE_NONE = 2'd0,
        RULE_13S  = 2'd1,
        RULE_22S  = 2'd2,
        RULE_12S  = 2'd3
    } t_rule;

    // classification of the sample now at the input
    typedef struct packed {
        logic [ZONE_W-1:0] flags;
        logic              beyond3;
        logic              range_raw;
    } t_zone_info;

    // one result item
    typedef struct packed {
        t_rule primary_rule;
        logic  range_violation;
        logic  four_one_violation;
        logic  ten_mean_violation;
    } t_result;

endpackage

[rtl/core/wmrc_zone.sv]
// settings registers, precomputed limits and zone classification of one sample
module wmrc_zone (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_index,
    input  logic [wmrc_pkg::SAMPLE_W-1:0]     i_cfg_data,
    input  logic                              i_accept,
    input  logic signed [wmrc_pkg::SAMPLE_W-1:0] i_sample,
    output wmrc_pkg::t_zone_info              o_zone
);

    localparam int TW = wmrc_pkg::THR_W;
    localparam int SW = wmrc_pkg::SAMPLE_W;

    logic signed [SW-1:0]           r_mean, n_mean;
    logic [wmrc_pkg::STD_W-1:0]     r_std, n_std;
    logic signed [TW-1:0]           r_hi1, r_hi2, r_hi3, r_lo1, r_lo2, r_lo3, r_mid;
    logic signed [TW-1:0]           n_hi1, n_hi2, n_hi3, n_lo1, n_lo2, n_lo3, n_mid;
    logic [SW:0]                    r_four_s, n_four_s;
    logic signed [SW-1:0]           r_prev;

    logic signed [TW-1:0]           s1, s2, s3;
    logic signed [TW-1:0]           x19;
    logic signed [SW:0]             diff;
    logic [SW:0]                    abs_diff;

    // next settings on a register write
    always_comb begin
        n_mean = r_mean;
        n_std  = r_std;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wmrc_pkg::CFG_TARGET_MEAN: n_mean = i_cfg_data;
                wmrc_pkg::CFG_STD_DEV:     n_std  = i_cfg_data[wmrc_pkg::STD_W-1:0];
                default:                   n_mean = r_mean;
            endcase
        end
    end

    // limits mean +/- k deviations, built from the new settings
    always_comb begin
        s1       = {{(TW-wmrc_pkg::STD_W){1'b0}}, n_std};
        s2       = s1 <<< 1;
        s3       = s2 + s1;
        n_mid    = {{(TW-SW){n_mean[SW-1]}}, n_mean};
        n_hi1    = n_mid + s1;
        n_hi2    = n_mid + s2;
        n_hi3    = n_mid + s3;
        n_lo1    = n_mid - s1;
        n_lo2    = n_mid - s2;
        n_lo3    = n_mid - s3;
        n_four_s = {n_std, 2'b00};
    end

    // settings and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_std    <= wmrc_pkg::STD_W'(1);
            r_mid    <= '0;
            r_hi1    <= TW'(1);
            r_hi2    <= TW'(2);
            r_hi3    <= TW'(3);
            r_lo1    <= -TW'(1);
            r_lo2    <= -TW'(2);
            r_lo3    <= -TW'(3);
            r_four_s <= (SW+1)'(4);
        end else begin
            r_mean   <= n_mean;
            r_std    <= n_std;
            r_mid    <= n_mid;
            r_hi1    <= n_hi1;
            r_hi2    <= n_hi2;
            r_hi3    <= n_hi3;
            r_lo1    <= n_lo1;
            r_lo2    <= n_lo2;
            r_lo3    <= n_lo3;
            r_four_s <= n_four_s;
        end
    end

    // previous sample for the range rule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_accept) begin
            r_prev <= i_sample;
        end
    end

    // compare the sample against the limits
    always_comb begin
        x19      = {{(TW-SW){i_sample[SW-1]}}, i_sample};
        diff     = {i_sample[SW-1], i_sample} - {r_prev[SW-1], r_prev};
        abs_diff = diff[SW] ? (SW+1)'(-diff) : diff;

        o_zone.flags                  = '0;
        o_zone.flags[wmrc_pkg::ZB_HI2] = x19 > r_hi2;
        o_zone.flags[wmrc_pkg::ZB_LO2] = x19 < r_lo2;
        o_zone.flags[wmrc_pkg::ZB_HI1] = x19 > r_hi1;
        o_zone.flags[wmrc_pkg::ZB_LO1] = x19 < r_lo1;
        o_zone.flags[wmrc_pkg::ZB_POS] = x19 > r_mid;
        o_zone.flags[wmrc_pkg::ZB_NEG] = x19 < r_mid;
        o_zone.beyond3                = (x19 > r_hi3) || (x19 < r_lo3);
        o_zone.range_raw              = abs_diff > r_four_s;
    end

endmodule

[rtl/core/wmrc_cell.sv]
// one history cell: stores the zone flags of one earlier sample and extends the run chain
module wmrc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [wmrc_pkg::ZONE_W-1:0]   i_flags,
    input  logic [wmrc_pkg::ZONE_W-1:0]   i_run,
    output logic [wmrc_pkg::ZONE_W-1:0]   o_flags,
    output logic [wmrc_pkg::ZONE_W-1:0]   o_run
);

    logic [wmrc_pkg::ZONE_W-1:0] r_flags;

    // shift in the neighbor's flags on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_shift) begin
            r_flags <= i_flags;
        end
    end

    // a flag survives the run only if this cell carries it too
    assign o_run   = i_run & r_flags;
    assign o_flags = r_flags;

endmodule

[rtl/core/wmrc_out.sv]
// output register with a skid stage for the result channel
module wmrc_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wmrc_pkg::t_result   i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output wmrc_pkg::t_result   o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    wmrc_pkg::t_result r_out;
    wmrc_pkg::t_result r_skid;
    logic              take;

    assign take = r_out_valid && !i_stall;

    // output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_data;
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/core/westgard_multirule_checker_unit.sv]
// Westgard multirule checker: one sample per clock unless the result channel stalls.
// Each result is registered in the output register, or in the skid register while the
// output is held. The classify stage and the history cell row each update once per
// transfer, and a skid stage keeps input open while a result waits.
// Reset: mean 0, deviation 1, history cells, sample count and previous sample cleared,
// no result pending.
module westgard_multirule_checker_unit #(
    parameter int MEAN_RUN_LENGTH    = wmrc_pkg::MEAN_RUN_DEFAULT,
    parameter int ONE_DEV_RUN_LENGTH = wmrc_pkg::ONE_DEV_RUN_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_index,
    input  logic [wmrc_pkg::SAMPLE_W-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [wmrc_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_primary_rule,
    output logic                                  o_range_violation,
    output logic                                  o_four_one_violation,
    output logic                                  o_ten_mean_violation
);

    localparam int HIST_DEPTH =
        ((MEAN_RUN_LENGTH > ONE_DEV_RUN_LENGTH) ? MEAN_RUN_LENGTH : ONE_DEV_RUN_LENGTH) - 1;
    localparam int SW = wmrc_pkg::SEEN_W;
    localparam logic [SW-1:0] SEEN_MAX = {SW{1'b1}};

    logic                         accept;
    wmrc_pkg::t_zone_info         zone;
    wmrc_pkg::t_result            result;
    wmrc_pkg::t_result            out_data;
    logic [wmrc_pkg::ZONE_W-1:0]  cell_flags [HIST_DEPTH];
    logic [wmrc_pkg::ZONE_W-1:0]  cell_run   [HIST_DEPTH];
    logic [SW-1:0]                r_seen;
    logic                         has_prev;
    logic [wmrc_pkg::ZONE_W-1:0]  run_one;
    logic [wmrc_pkg::ZONE_W-1:0]  run_mean;

    assign accept = i_valid && !o_stall;

    // classify the incoming sample
    wmrc_zone u_zone (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .o_zone      (zone)
    );

    // row of history cells, most recent first
    for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            wmrc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_flags (zone.flags),
                .i_run   (zone.flags),
                .o_flags (cell_flags[g]),
                .o_run   (cell_run[g])
            );
        end else begin : g_body
            wmrc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_flags (cell_flags[g-1]),
                .i_run   (cell_run[g-1]),
                .o_flags (cell_flags[g]),
                .o_run   (cell_run[g])
            );
        end
    end

    // saturating count of earlier samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept && (r_seen != SEEN_MAX)) begin
            r_seen <= r_seen + SW'(1);
        end
    end

    // rule evaluation
    always_comb begin
        has_prev = r_seen != '0;
        run_one  = cell_run[ONE_DEV_RUN_LENGTH-2];
        run_mean = cell_run[MEAN_RUN_LENGTH-2];

        if (zone.beyond3) begin
            result.primary_rule = wmrc_pkg::RULE_13S;
        end else if (has_prev &&
                     ((zone.flags[wmrc_pkg::ZB_HI2] && cell_flags[0][wmrc_pkg::ZB_HI2]) ||
                      (zone.flags[wmrc_pkg::ZB_LO2] && cell_flags[0][wmrc_pkg::ZB_LO2]))) begin
            result.primary_rule = wmrc_pkg::RULE_22S;
        end else if (zone.flags[wmrc_pkg::ZB_HI2] || zone.flags[wmrc_pkg::ZB_LO2]) begin
            result.primary_rule = wmrc_pkg::RULE_12S;
        end else begin
            result.primary_rule = wmrc_pkg::RULE_NONE;
        end

        result.range_violation    = has_prev && zone.range_raw;
        result.four_one_violation = (r_seen >= SW'(ONE_DEV_RUN_LENGTH - 1)) &&
                                    (run_one[wmrc_pkg::ZB_HI1] || run_one[wmrc_pkg::ZB_LO1]);
        result.ten_mean_violation = (r_seen >= SW'(MEAN_RUN_LENGTH - 1)) &&
                                    (run_mean[wmrc_pkg::ZB_POS] || run_mean[wmrc_pkg::ZB_NEG]);
    end

    // result channel
    wmrc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_primary_rule       = out_data.primary_rule;
    assign o_range_violation    = out_data.range_violation;
    assign o_four_one_violation = out_data.four_one_violation;
    assign o_ten_mean_violation = out_data.ten_mean_violation;

    // head cell takes the flags of the transferred sample
    a_head_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> cell_flags[0] == $past(zone.flags))
        else $error("head history cell missed the transferred sample flags");

    // sample count advances by one per transfer until saturation
    a_seen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_seen != SEEN_MAX)) |=> r_seen == $past(r_seen) + SW'(1))
        else $error("sample count did not advance on transfer");

    // a sample cannot lie beyond one deviation on both sides
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(zone.flags[wmrc_pkg::ZB_HI1] && zone.flags[wmrc_pkg::ZB_LO1]))
        else $error("zone flags claim both sides of the mean");

    // the skid stage only fills behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid stage full while output register empty");

endmodule

[tb/wmrc_rule_checker.sv]
// scoreboard for the westgard multirule checker: predicts each result and compares it
module wmrc_rule_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [15:0]          i_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [1:0]                  i_primary_rule,
    input  logic                        i_range_violation,
    input  logic                        i_four_one_violation,
    input  logic                        i_ten_mean_violation,
    output int                          o_fail_count,
    output int                          o_results_seen
);

    localparam int HIST_DEPTH =
        (wmrc_pkg::MEAN_RUN_DEFAULT > wmrc_pkg::ONE_DEV_RUN_DEFAULT ?
         wmrc_pkg::MEAN_RUN_DEFAULT : wmrc_pkg::ONE_DEV_RUN_DEFAULT) - 1;

    // predictor copy of the block's settings and history
    logic signed [wmrc_pkg::SAMPLE_W-1:0] mean_q;
    logic [wmrc_pkg::STD_W-1:0]           dev_q;
    logic signed [wmrc_pkg::SAMPLE_W-1:0] last_sample;
    logic [wmrc_pkg::ZONE_W-1:0]          zone_hist [0:HIST_DEPTH-1];
    logic [wmrc_pkg::SEEN_W-1:0]          seen_cnt;

    wmrc_pkg::t_result pending_rules [$];

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
    end

    // true when the current sample and the len-1 newest stored ones all carry the flag
    function automatic bit run_on_side(input logic [wmrc_pkg::ZONE_W-1:0] cur,
                                       input int flag, input int len);
        if (int'(seen_cnt) < len - 1 || !cur[flag])
            return 1'b0;
        for (int i = 0; i < len - 1; i++) begin
            if (!zone_hist[i][flag])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // classify one sample, work out its rules and advance the history
    function automatic wmrc_pkg::t_result judge_sample(
        input logic signed [wmrc_pkg::SAMPLE_W-1:0] x);
        int                          m;
        int                          s;
        int                          xi;
        int                          diff;
        logic                        beyond3;
        logic [wmrc_pkg::ZONE_W-1:0] z;
        wmrc_pkg::t_result           r;
        m  = mean_q;
        s  = int'(dev_q);
        xi = x;
        z  = '0;
        z[wmrc_pkg::ZB_HI2] = xi > m + 2 * s;
        z[wmrc_pkg::ZB_LO2] = xi < m - 2 * s;
        z[wmrc_pkg::ZB_HI1] = xi > m + s;
        z[wmrc_pkg::ZB_LO1] = xi < m - s;
        z[wmrc_pkg::ZB_POS] = xi > m;
        z[wmrc_pkg::ZB_NEG] = xi < m;
        beyond3   = (xi > m + 3 * s) || (xi < m - 3 * s);

        r = '0;
        r.primary_rule = wmrc_pkg::RULE_NONE;
        if (beyond3)
            r.primary_rule = wmrc_pkg::RULE_13S;
        else if (seen_cnt >= 1 &&
                 ((z[wmrc_pkg::ZB_HI2] && zone_hist[0][wmrc_pkg::ZB_HI2]) ||
                  (z[wmrc_pkg::ZB_LO2] && zone_hist[0][wmrc_pkg::ZB_LO2])))
            r.primary_rule = wmrc_pkg::RULE_22S;
        else if (z[wmrc_pkg::ZB_HI2] || z[wmrc_pkg::ZB_LO2])
            r.primary_rule = wmrc_pkg::RULE_12S;

        if (seen_cnt >= 1) begin
            diff = xi - int'(last_sample);
            if (diff < 0)
                diff = -diff;
            r.range_violation = diff > 4 * s;
        end
        r.four_one_violation =
            run_on_side(z, wmrc_pkg::ZB_HI1, wmrc_pkg::ONE_DEV_RUN_DEFAULT) ||
            run_on_side(z, wmrc_pkg::ZB_LO1, wmrc_pkg::ONE_DEV_RUN_DEFAULT);
        r.ten_mean_violation =
            run_on_side(z, wmrc_pkg::ZB_POS, wmrc_pkg::MEAN_RUN_DEFAULT) ||
            run_on_side(z, wmrc_pkg::ZB_NEG, wmrc_pkg::MEAN_RUN_DEFAULT);

        for (int i = HIST_DEPTH - 1; i > 0; i--)
            zone_hist[i] = zone_hist[i - 1];
        zone_hist[0] = z;
        last_sample  = x;
        if (seen_cnt != '1)
            seen_cnt = seen_cnt + 1'b1;
        return r;
    endfunction

    // watch configuration writes and both transfer channels
    always @(posedge i_clk) begin : watch
        wmrc_pkg::t_result want;
        if (!i_rst_n) begin
            mean_q      = '0;
            dev_q       = 15'd1;
            last_sample = '0;
            seen_cnt    = '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                zone_hist[i] = '0;
            pending_rules.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == wmrc_pkg::CFG_TARGET_MEAN)
                    mean_q = i_cfg_data;
                else if (i_cfg_index == wmrc_pkg::CFG_STD_DEV)
                    dev_q = i_cfg_data[wmrc_pkg::STD_W-1:0];
            end

            // result transfer: compare against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (pending_rules.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_rules.pop_front();
                    if (i_primary_rule !== want.primary_rule) begin
                        $error("primary_rule: expected %0d, actual %0d",
                               want.primary_rule, i_primary_rule);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_range_violation !== want.range_violation) begin
                        $error("range_violation: expected %0d, actual %0d",
                               want.range_violation, i_range_violation);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_four_one_violation !== want.four_one_violation) begin
                        $error("four_one_violation: expected %0d, actual %0d",
                               want.four_one_violation, i_four_one_violation);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_ten_mean_violation !== want.ten_mean_violation) begin
                        $error("ten_mean_violation: expected %0d, actual %0d",
                               want.ten_mean_violation, i_ten_mean_violation);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end

            // sample transfer: predict its result
            if (i_in_valid && !i_in_stall)
                pending_rules.push_back(judge_sample(i_sample));
        end
    end

endmodule

[tb/testbench.sv]
// stimulus and verdict for the westgard multirule checker
module testbench;

    localparam int QUIET_LIMIT = 3000;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [0:0]                 i_cfg_index = wmrc_pkg::CFG_TARGET_MEAN;
    logic [15:0]                i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [15:0]         i_sample = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [1:0]                 o_primary_rule;
    logic                       o_range_violation;
    logic                       o_four_one_violation;
    logic                       o_ten_mean_violation;

    int fail_count;
    int results_seen;
    int samples_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_run = 0;
    int quiet_cycles = 0;

    // edge cases around mean 0 and deviation 1000
    int directed_vals [] = '{32767, -32768, 0, 1000, 1001, 2000, 2001, 2500, 3000, 3001,
                             -2500, -2600, 4000, 1200, 1300, 1400, 1500, 500, 600, 700,
                             800, 900, 999};

    westgard_multirule_checker_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_sample             (i_sample),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_primary_rule       (o_primary_rule),
        .o_range_violation    (o_range_violation),
        .o_four_one_violation (o_four_one_violation),
        .o_ten_mean_violation (o_ten_mean_violation)
    );

    wmrc_rule_checker scoreboard (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_valid),
        .i_in_stall           (o_stall),
        .i_sample             (i_sample),
        .i_out_valid          (o_valid),
        .i_out_stall          (i_stall),
        .i_primary_rule       (o_primary_rule),
        .i_range_violation    (o_range_violation),
        .i_four_one_violation (o_four_one_violation),
        .i_ten_mean_violation (o_ten_mean_violation),
        .o_fail_count         (fail_count),
        .o_results_seen       (results_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result-side stall: mostly short bursts, now and then a long one
    always @(posedge i_clk) begin : receiver
        int roll;
        roll = $urandom_range(99, 0);
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (roll < stall_pct) begin
            i_stall   <= 1'b1;
            stall_run <= (roll < 3) ? $urandom_range(40, 10) : $urandom_range(2, 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll >= gap_pct)
            return 0;
        return (roll < 3) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // one sample transfer, then an optional idle gap
    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        i_valid  <= 1'b1;
        i_sample <= x;
        do
            @(posedge i_clk);
        while (o_stall);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        i_valid <= 1'b0;
        while (results_seen != samples_sent)
            @(posedge i_clk);
    endtask

    // write both registers while the block is idle
    task automatic load_settings(input int mean, input int dev, input bit top_bit);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= wmrc_pkg::CFG_TARGET_MEAN;
        i_cfg_data  <= 16'(mean);
        @(posedge i_clk);
        i_cfg_index <= wmrc_pkg::CFG_STD_DEV;
        i_cfg_data  <= {top_bit, 15'(dev)};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // runs on one side of the mean with random depth, boundary hits and noise
    task automatic random_phase(input int mean, input int dev, input int n_items);
        int count;
        int roll;
        int side;
        int burst;
        int k;
        count = 0;
        while (count < n_items) begin
            roll = $urandom_range(99, 0);
            side = $urandom_range(1, 0) ? 1 : -1;
            if (roll < 65) begin
                burst = $urandom_range(14, 3);
                for (int i = 0; i < burst; i++) begin
                    if ($urandom_range(9, 0) == 0) begin
                        k = $urandom_range(4, 0);
                        send_sample(clamp16(mean + side * k * dev +
                                            int'($urandom_range(2, 0)) - 1));
                    end else begin
                        send_sample(clamp16(mean + side *
                                            int'($urandom_range(4 * dev + 1, 0))));
                    end
                end
                count += burst;
            end else if (roll < 85) begin
                k = $urandom_range(4, 0);
                send_sample(clamp16(mean + side * k * dev + int'($urandom_range(2, 0)) - 1));
                count++;
            end else begin
                send_sample(16'(int'($urandom_range(65535, 0))));
                count++;
            end
        end
    endtask

    // main sequence
    initial begin
        int mean;
        int dev;
        bit top_bit;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_settings(0, 1000, 1'b0);
        foreach (directed_vals[i])
            send_sample(16'(directed_vals[i]));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            top_bit = 1'b0;
            case (ph)
                0: begin
                    mean = -32768;
                    dev  = 32767;
                end
                1: begin
                    mean = 32767;
                    dev  = 0;
                end
                2: begin
                    mean = 0;
                    dev  = 0;
                end
                3: begin
                    mean = int'($urandom_range(65535, 0)) - 32768;
                    dev  = $urandom_range(64, 1);
                end
                4: begin
                    mean = int'($urandom_range(4000, 0)) - 2000;
                    dev  = $urandom_range(3000, 100);
                end
                5: begin
                    mean = int'($urandom_range(65535, 0)) - 32768;
                    dev  = $urandom_range(32767, 0);
                end
                default: begin
                    mean    = int'($urandom_range(20000, 0)) - 10000;
                    dev     = $urandom_range(500, 10);
                    top_bit = 1'b1;
                end
            endcase
            gap_pct   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 20 : 50);
            stall_pct = (ph % 3 == 1) ? 0 : ((ph % 3 == 2) ? 25 : 50);
            load_settings(mean, dev, top_bit);
            random_phase(mean, dev, 72);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
